[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CFD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

`define CFD_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define CFD_ASSERT(name, clk, rstn, prop)

`define CFD_ASSERT_IMP(name, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/cfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and helper functions shared by the frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;
    localparam logic [10:0] POS_LIMIT   = 11'd2047;
    localparam logic [10:0] HDR_BYTES   = 11'd8;
    localparam logic [10:0] CRC_BYTES   = 11'd4;
    localparam logic [10:0] MIN_BYTES   = HDR_BYTES + CRC_BYTES;
    localparam logic [15:0] SYNC_RESET  = 16'h55AA;
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

    localparam logic [10:0] POS_SYNC_LO = 11'd0;
    localparam logic [10:0] POS_SYNC_HI = 11'd1;
    localparam logic [10:0] POS_SEQ_LO  = 11'd2;
    localparam logic [10:0] POS_SEQ_HI  = 11'd3;
    localparam logic [10:0] POS_LEN_LO  = 11'd4;
    localparam logic [10:0] POS_LEN_HI  = 11'd5;
    localparam logic [10:0] POS_KIND    = 11'd6;
    localparam logic [10:0] POS_FLAGS   = 11'd7;

    localparam logic [7:0] KIND_DATA     = 8'h00;
    localparam logic [7:0] KIND_CTRL     = 8'h01;
    localparam logic [7:0] KIND_CMD_LO   = 8'h10;
    localparam logic [7:0] KIND_CMD_HI   = 8'h13;
    localparam logic [7:0] KIND_DEBUG    = 8'hFE;
    localparam logic [7:0] KIND_RESERVED = 8'hFF;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_SYNC     = 3'd2,
        ST_LEN_BIG  = 3'd3,
        ST_SIZE     = 3'd4,
        ST_CRC      = 3'd5,
        ST_BAD_KIND = 3'd6
    } status_t;

    typedef struct packed {
        logic short_frame;
        logic sync_bad;
        logic len_big;
        logic size_bad;
        logic crc_bad;
        logic kind_bad;
    } check_flags_t;

    typedef struct packed {
        logic         is_verdict;
        logic [7:0]   payload_byte;
        check_flags_t checks;
        logic [15:0]  sequence_num;
        logic [7:0]   kind;
        logic [7:0]   flags;
        logic [10:0]  length;
    } job_t;

    typedef logic [31:0] crc_table_t [256];

    function automatic crc_table_t crc_table_gen();
        crc_table_t tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

    function automatic logic kind_ok(input logic [7:0] t);
        return (t == KIND_DATA) || (t == KIND_CTRL) ||
               ((t >= KIND_CMD_LO) && (t <= KIND_CMD_HI)) ||
               (t == KIND_DEBUG) || (t == KIND_RESERVED);
    endfunction

endpackage

[hw/rtl/cfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_front
// Accepts frame bytes, tracks header, CRC and position, and issues jobs.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  logic          q_full,
    output logic          q_push,
    output cfd_pkg::job_t q_job
);
    import cfd_pkg::*;

    logic [15:0] sync_pattern_reg;
    logic [10:0] pos_reg, pos_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] tail_reg, tail_next;
    logic        sync_ok_reg, sync_ok_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  flags_reg, flags_next;

    logic        accept;
    logic        emit;
    logic [31:0] crc_upd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        crc_upd   = CRC_TABLE[crc_reg[7:0] ^ tail_reg[7:0]] ^ {8'h00, crc_reg[31:8]};
        crc_next  = (pos_reg >= CRC_BYTES) ? crc_upd : crc_reg;
        tail_next = {s_tdata, tail_reg[31:8]};
        pos_next  = (pos_reg < POS_LIMIT) ? pos_reg + 11'd1 : pos_reg;

        sync_ok_next = sync_ok_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        kind_next    = kind_reg;
        flags_next   = flags_reg;
        unique case (pos_reg)
            POS_SYNC_LO: sync_ok_next = (s_tdata == sync_pattern_reg[7:0]);
            POS_SYNC_HI: sync_ok_next = sync_ok_reg && (s_tdata == sync_pattern_reg[15:8]);
            POS_SEQ_LO:  seq_next     = {8'h00, s_tdata};
            POS_SEQ_HI:  seq_next     = {s_tdata, seq_reg[7:0]};
            POS_LEN_LO:  len_next     = {8'h00, s_tdata};
            POS_LEN_HI:  len_next     = {s_tdata, len_reg[7:0]};
            POS_KIND:    kind_next    = s_tdata;
            POS_FLAGS:   flags_next   = s_tdata;
            default:     ;
        endcase

        emit = !s_tlast && (pos_reg >= HDR_BYTES) && (len_reg <= 16'(MAX_PAYLOAD)) &&
               ({6'd0, pos_reg} < ({6'd0, HDR_BYTES} + {1'b0, len_reg}));

        q_push                   = accept && (s_tlast || emit);
        q_job.is_verdict         = s_tlast;
        q_job.payload_byte       = s_tlast ? 8'h00 : s_tdata;
        q_job.checks.short_frame = pos_next < MIN_BYTES;
        q_job.checks.sync_bad    = !sync_ok_next;
        q_job.checks.len_big     = len_next > 16'(MAX_PAYLOAD);
        q_job.checks.size_bad    = {6'd0, pos_next} != ({6'd0, MIN_BYTES} + {1'b0, len_next});
        q_job.checks.crc_bad     = (~crc_next) != tail_next;
        q_job.checks.kind_bad    = !kind_ok(kind_next);
        q_job.sequence_num       = seq_next;
        q_job.kind               = kind_next;
        q_job.flags              = flags_next;
        q_job.length             = len_next[10:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_pattern_reg <= SYNC_RESET;
        end else if (cfg_wr_en) begin
            sync_pattern_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            pos_reg     <= '0;
            crc_reg     <= CRC_INIT;
            tail_reg    <= '0;
            sync_ok_reg <= 1'b0;
            seq_reg     <= '0;
            len_reg     <= '0;
            kind_reg    <= '0;
            flags_reg   <= '0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            tail_reg    <= tail_next;
            sync_ok_reg <= sync_ok_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            kind_reg    <= kind_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

[hw/rtl/cfd_queue.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cfd_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cfd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output cfd_pkg::job_t pop_job
);
    import cfd_pkg::*;

    job_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CFD_ASSERT(a_no_overflow, aclk, aresetn, !(push && full && !pop))
    `CFD_ASSERT(a_no_underflow, aclk, aresetn, !(pop && !not_empty))
    `CFD_ASSERT(a_count_range, aclk, aresetn, count_reg <= 2'd2)
    `CFD_ASSERT_IMP(a_ptr_balance, aclk, aresetn, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg)

endmodule

[hw/rtl/cfd_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// cfd_back
// Resolves the verdict status and drives the registered output channel.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_not_empty,
    input  cfd_pkg::job_t q_job,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,
    output logic          m_tuser
);
    import cfd_pkg::*;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    status_t     status;
    logic        ok;

    assign q_pop = q_not_empty && (!m_tvalid_reg || m_tready);

    always_comb begin
        priority if (q_job.checks.short_frame) begin
            status = ST_SHORT;
        end else if (q_job.checks.sync_bad) begin
            status = ST_SYNC;
        end else if (q_job.checks.len_big) begin
            status = ST_LEN_BIG;
        end else if (q_job.checks.size_bad) begin
            status = ST_SIZE;
        end else if (q_job.checks.crc_bad) begin
            status = ST_CRC;
        end else if (q_job.checks.kind_bad) begin
            status = ST_BAD_KIND;
        end else begin
            status = ST_OK;
        end

        ok            = q_job.is_verdict && (status == ST_OK);
        m_tuser_next  = q_job.is_verdict;
        m_tdata_next  = {
            2'b00,
            ok ? q_job.length : 11'd0,
            ok ? q_job.flags : 8'h00,
            ok ? q_job.kind : 8'h00,
            ok ? q_job.sequence_num : 16'h0000,
            q_job.is_verdict ? status : ST_OK,
            q_job.is_verdict ? 8'h00 : q_job.payload_byte
        };
        m_tvalid_next = q_pop ? 1'b1 : (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CFD_ASSERT_IMP(a_verdict_no_byte, aclk, aresetn, m_tvalid_reg && m_tuser_reg, m_tdata_reg[7:0] == 8'h00)
    `CFD_ASSERT_IMP(a_payload_clean, aclk, aresetn, m_tvalid_reg && !m_tuser_reg, m_tdata_reg[55:8] == '0)
    `CFD_ASSERT_IMP(a_fail_no_header, aclk, aresetn, m_tvalid_reg && (m_tdata_reg[10:8] != ST_OK), m_tdata_reg[55:11] == '0)
    `CFD_ASSERT_IMP(a_hold_on_stall, aclk, aresetn, m_tvalid_reg && !m_tready, ##1 (m_tvalid_reg && $stable(m_tdata_reg)))

endmodule

[hw/rtl/crc32_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_frame_deframer
// Streaming parser for sync/length/CRC-32 frames. The block takes one frame
// byte per cycle with no gaps required while the queue is not full: the byte
// counter, header capture and table-driven CRC-32 update each finish a byte
// as it is accepted. A result is written into the queue and then into the
// output register. Payload bytes are passed on as they arrive (tuser low),
// and the byte marked with tlast yields one verdict (tuser high) with the
// status and, when the status is ok, the decoded header. A two-entry queue and
// the output register let input keep flowing while a result waits to be
// taken. The sync word is set through cfg_wr_en and cfg_wr_data; the user must
// write it only while no frame is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module crc32_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
                                   // [26:11] sequence_res, [34:27] frame_kind,
                                   // [42:35] frame_flags, [53:43] payload_length
    output logic        m_tuser    // [0] is_verdict
);
    import cfd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    job_t push_job;
    job_t pop_job;

    cfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    cfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (pop_job)
    );

    cfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule
